// ----- design/orbit_camera_update_assert.svh -----
// Assertion macros for the orbit camera block.
`ifndef ORBIT_CAMERA_UPDATE_ASSERT_SVH
`define ORBIT_CAMERA_UPDATE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define OCU_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define OCU_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/ocu_pkg.sv -----
// Constants and the arctangent table of the orbit camera block.
package ocu_pkg;

    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int POSITION_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ACT_ROTATE = 2'd0,
        ACT_PAN_XY = 2'd1,
        ACT_PAN_Z  = 2'd2,
        ACT_SCROLL = 2'd3
    } t_action;

    localparam logic signed [17:0] CORDIC_GAIN = 18'sd39797;
    localparam logic signed [17:0] PAN_SCALE_K = 18'sd50332;
    localparam logic signed [17:0] ZOOM_OUT_K  = 18'sd75366;
    localparam logic signed [17:0] ZOOM_IN_K   = 18'sd56988;
    localparam logic [25:0]        RANGE_RESET = 26'd655360;
    localparam logic signed [63:0] RANGE_MAX   = 64'sd65536000;
    localparam logic signed [63:0] RANGE_MIN   = 64'sd66;
    localparam logic signed [18:0] AZ_HALF     = 19'sd46080;
    localparam logic signed [18:0] AZ_FULL     = 19'sd92160;
    localparam logic signed [16:0] EL_LIMIT    = 17'sd22784;
    localparam logic signed [24:0] DEG90_Q16   = 25'sd5898240;
    localparam logic signed [24:0] DEG180_Q16  = 25'sd11796480;

    // atan(2^-i) in degrees, Q.16
    function automatic logic [22:0] atan_q16(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/orbit_camera_update.sv -----
// Orbit camera state engine: event update, CORDIC sin/cos and eye position.
//
// Takes one mouse event at a time (rotate, pan in xy, pan in z, scroll) and
// returns the eye position, focus, distance and angles after it. The input
// stalls from the transfer until the result is loaded into the output
// register. Pan in xy adds a pass through the pan product states, and pan in z
// or a scroll that moves adds a multiply; the iterative CORDIC, run once per
// angle, and the single shared 27x18 multiplier serve every event. A new
// event may be taken while the previous result still waits at the output.
module orbit_camera_update #(
    parameter int CORDIC_STEPS   = ocu_pkg::CORDIC_STEPS_DEF,
    parameter int POSITION_WIDTH = ocu_pkg::POSITION_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    input  logic signed [1:0]  i_wheel,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_eye_x,
    output logic signed [31:0] o_eye_y,
    output logic signed [31:0] o_eye_z,
    output logic signed [31:0] o_focus_x,
    output logic signed [31:0] o_focus_y,
    output logic signed [31:0] o_focus_z,
    output logic [25:0]        o_range_out,
    output logic signed [16:0] o_azimuth_out,
    output logic signed [15:0] o_elevation_out
);
    `include "orbit_camera_update_assert.svh"

    localparam int PW    = POSITION_WIDTH;
    localparam int StepW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);
    localparam logic signed [63:0] PosMax = (64'sd1 <<< (PW - 1)) - 64'sd1;
    localparam logic signed [63:0] PosMin = -PosMax - 64'sd1;

    typedef enum logic [4:0] {
        S_IDLE, S_MSCALE, S_SCALE, S_MPANZ, S_PANZ, S_MZOOM, S_ZOOM,
        S_CLOAD, S_COR,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_E1, S_E2, S_E3, S_E4, S_E5, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        COR_PAN, COR_AZ, COR_EL
    } t_cor_tgt;

    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [63:0] rnd32(input logic signed [63:0] v);
        return (v + 64'sd2147483648) >>> 32;
    endfunction

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > PosMax) r = PosMax;
        if (v < PosMin) r = PosMin;
        return PW'(r);
    endfunction

    t_state   r_state;
    t_cor_tgt r_ctgt;

    logic [1:0]         r_action;
    logic signed [15:0] r_mx;
    logic signed [15:0] r_my;
    logic signed [1:0]  r_wh;

    logic signed [16:0] r_az;
    logic signed [15:0] r_el;
    logic [25:0]        r_range;
    logic signed [PW-1:0] r_fx, r_fy, r_fz;

    logic [25:0]        r_scale;
    logic signed [44:0] r_prod;
    logic signed [44:0] r_acc;
    logic signed [34:0] r_t, r_u;
    logic signed [26:0] r_rc;
    logic signed [17:0] r_sa, r_ca, r_se, r_ce;
    logic signed [PW-1:0] r_ex, r_ey, r_ez;

    logic [StepW-1:0]   r_cstep;
    logic signed [24:0] r_cz;
    logic signed [19:0] r_cx, r_cy;
    logic               r_cneg;

    logic               r_out_valid;
    logic signed [PW-1:0] r_oex, r_oey, r_oez, r_ofx, r_ofy, r_ofz;
    logic [25:0]        r_orange;
    logic signed [16:0] r_oaz;
    logic signed [15:0] r_oel;

    logic signed [26:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [26:0] range_s;
    logic signed [26:0] scale_s;

    logic signed [19:0] cor_dx, cor_dy, cor_nx, cor_ny;
    logic signed [24:0] cor_at, cor_nz, cor_z0;
    logic signed [16:0] cor_ang;

    logic signed [18:0] rot_az;
    logic signed [16:0] rot_el;
    logic signed [63:0] zoom_v;
    logic signed [63:0] pan_v;
    logic               out_load;

    assign range_s = $signed({1'b0, r_range});
    assign scale_s = $signed({1'b0, r_scale});
    // result register free, or its transfer happens now
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // shared multiplier operands
    always_comb begin
        mul_a = range_s;
        mul_b = ocu_pkg::PAN_SCALE_K;
        case (r_state)
            S_MSCALE: begin mul_a = range_s; mul_b = ocu_pkg::PAN_SCALE_K; end
            S_MPANZ:  begin mul_a = scale_s; mul_b = 18'(r_my); end
            S_MZOOM: begin
                mul_a = range_s;
                mul_b = r_wh[1] ? ocu_pkg::ZOOM_IN_K : ocu_pkg::ZOOM_OUT_K;
            end
            S_P1: begin mul_a = 27'(r_mx); mul_b = r_ca; end
            S_P2: begin mul_a = 27'(r_my); mul_b = r_sa; end
            S_P3: begin mul_a = 27'(r_mx); mul_b = r_sa; end
            S_P4: begin mul_a = 27'(r_my); mul_b = r_ca; end
            S_P5: begin mul_a = scale_s; mul_b = $signed({1'b0, r_t[16:0]}); end
            S_P6: begin mul_a = scale_s; mul_b = r_t[34:17]; end
            S_P7: begin mul_a = scale_s; mul_b = $signed({1'b0, r_u[16:0]}); end
            S_P8: begin mul_a = scale_s; mul_b = r_u[34:17]; end
            S_E1: begin mul_a = range_s; mul_b = r_ce; end
            S_E2: begin mul_a = range_s; mul_b = r_se; end
            S_E3: begin mul_a = r_rc; mul_b = r_ca; end
            S_E4: begin mul_a = r_rc; mul_b = r_sa; end
            default: begin mul_a = range_s; mul_b = ocu_pkg::PAN_SCALE_K; end
        endcase
    end

    // one CORDIC rotation step, and the folded start angle
    always_comb begin
        cor_dx = r_cy >>> r_cstep;
        cor_dy = r_cx >>> r_cstep;
        cor_at = $signed({2'b00, ocu_pkg::atan_q16(5'(r_cstep))});
        if (!r_cz[24]) begin
            cor_nx = r_cx - cor_dx;
            cor_ny = r_cy + cor_dy;
            cor_nz = r_cz - cor_at;
        end else begin
            cor_nx = r_cx + cor_dx;
            cor_ny = r_cy - cor_dy;
            cor_nz = r_cz + cor_at;
        end
        cor_ang = (r_ctgt == COR_EL) ? 17'(r_el) : r_az;
        cor_z0  = {cor_ang, 8'b0};
    end

    always_comb begin
        rot_az = 19'(r_az) + 19'(r_mx);
        if (rot_az > ocu_pkg::AZ_HALF) rot_az = rot_az - ocu_pkg::AZ_FULL;
        if (rot_az < -ocu_pkg::AZ_HALF) rot_az = rot_az + ocu_pkg::AZ_FULL;
        rot_el = 17'(r_el) + 17'(r_my);
        if (rot_el < -ocu_pkg::EL_LIMIT) rot_el = -ocu_pkg::EL_LIMIT;
        if (rot_el > ocu_pkg::EL_LIMIT) rot_el = ocu_pkg::EL_LIMIT;
        zoom_v = rnd16(64'(r_prod));
        if (!r_wh[1] && zoom_v > ocu_pkg::RANGE_MAX) zoom_v = ocu_pkg::RANGE_MAX;
        if (r_wh[1] && zoom_v < ocu_pkg::RANGE_MIN) zoom_v = ocu_pkg::RANGE_MIN;
        // scale * (hi * 2^17 + lo)
        pan_v = rnd32(64'(r_acc) + (64'(r_prod) <<< 17));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctgt      <= COR_AZ;
            r_out_valid <= 1'b0;
            r_az        <= '0;
            r_el        <= '0;
            r_range     <= ocu_pkg::RANGE_RESET;
            r_fx        <= '0;
            r_fy        <= '0;
            r_fz        <= '0;
            r_cstep     <= '0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action <= i_action;
                        r_mx     <= i_move_x;
                        r_my     <= i_move_y;
                        r_wh     <= i_wheel;
                        r_state  <= S_MSCALE;
                    end
                end
                S_MSCALE: r_state <= S_SCALE;
                S_SCALE: begin
                    r_scale <= 26'(rnd16(64'(r_prod)));
                    case (ocu_pkg::t_action'(r_action))
                        ocu_pkg::ACT_ROTATE: begin
                            r_az    <= 17'(rot_az);
                            r_el    <= 16'(rot_el);
                            r_ctgt  <= COR_AZ;
                            r_state <= S_CLOAD;
                        end
                        ocu_pkg::ACT_PAN_XY: begin
                            r_ctgt  <= COR_PAN;
                            r_state <= S_CLOAD;
                        end
                        ocu_pkg::ACT_PAN_Z: begin
                            r_ctgt  <= COR_AZ;
                            r_state <= S_MPANZ;
                        end
                        default: begin
                            r_ctgt  <= COR_AZ;
                            r_state <= (r_wh != 2'sd0) ? S_MZOOM : S_CLOAD;
                        end
                    endcase
                end
                S_MPANZ: r_state <= S_PANZ;
                S_PANZ: begin
                    r_fz    <= sat_pos(64'(r_fz) - rnd16(64'(r_prod)));
                    r_state <= S_CLOAD;
                end
                S_MZOOM: r_state <= S_ZOOM;
                S_ZOOM: begin
                    r_range <= 26'(zoom_v);
                    r_state <= S_CLOAD;
                end
                S_CLOAD: begin
                    r_cx    <= 20'(ocu_pkg::CORDIC_GAIN);
                    r_cy    <= '0;
                    r_cstep <= '0;
                    if (cor_z0 > ocu_pkg::DEG90_Q16) begin
                        r_cz   <= cor_z0 - ocu_pkg::DEG180_Q16;
                        r_cneg <= 1'b1;
                    end else if (cor_z0 < -ocu_pkg::DEG90_Q16) begin
                        r_cz   <= cor_z0 + ocu_pkg::DEG180_Q16;
                        r_cneg <= 1'b1;
                    end else begin
                        r_cz   <= cor_z0;
                        r_cneg <= 1'b0;
                    end
                    r_state <= S_COR;
                end
                S_COR: begin
                    r_cx    <= cor_nx;
                    r_cy    <= cor_ny;
                    r_cz    <= cor_nz;
                    r_cstep <= (r_cstep == LastStep) ? '0 : r_cstep + 1'b1;
                    if (r_cstep == LastStep) begin
                        if (r_ctgt == COR_EL) begin
                            r_se    <= 18'(r_cneg ? -cor_ny : cor_ny);
                            r_ce    <= 18'(r_cneg ? -cor_nx : cor_nx);
                            r_state <= S_E1;
                        end else begin
                            r_sa    <= 18'(r_cneg ? -cor_ny : cor_ny);
                            r_ca    <= 18'(r_cneg ? -cor_nx : cor_nx);
                            r_state <= (r_ctgt == COR_PAN) ? S_P1 : S_CLOAD;
                            r_ctgt  <= (r_ctgt == COR_PAN) ? COR_PAN : COR_EL;
                        end
                    end
                end
                S_P1: r_state <= S_P2;
                S_P2: begin
                    r_acc   <= r_prod;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_t     <= 35'(r_acc - r_prod);
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_acc   <= r_prod;
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_u     <= 35'(r_acc + r_prod);
                    r_state <= S_P6;
                end
                S_P6: begin
                    r_acc   <= r_prod;
                    r_state <= S_P7;
                end
                S_P7: begin
                    r_fy    <= sat_pos(64'(r_fy) + pan_v);
                    r_state <= S_P8;
                end
                S_P8: begin
                    r_acc   <= r_prod;
                    r_state <= S_P9;
                end
                S_P9: begin
                    r_fx    <= sat_pos(64'(r_fx) - pan_v);
                    r_ctgt  <= COR_EL;
                    r_state <= S_CLOAD;
                end
                S_E1: r_state <= S_E2;
                S_E2: begin
                    r_rc    <= 27'(rnd16(64'(r_prod)));
                    r_state <= S_E3;
                end
                S_E3: begin
                    r_ez    <= sat_pos(64'(r_fz) - rnd16(64'(r_prod)));
                    r_state <= S_E4;
                end
                S_E4: begin
                    r_ex    <= sat_pos(64'(r_fx) + rnd16(64'(r_prod)));
                    r_state <= S_E5;
                end
                S_E5: begin
                    r_ey    <= sat_pos(64'(r_fy) + rnd16(64'(r_prod)));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait until the previous result has been transferred
                    if (out_load) begin
                        r_oex       <= r_ex;
                        r_oey       <= r_ey;
                        r_oez       <= r_ez;
                        r_ofx       <= r_fx;
                        r_ofy       <= r_fy;
                        r_ofz       <= r_fz;
                        r_orange    <= r_range;
                        r_oaz       <= r_az;
                        r_oel       <= r_el;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_eye_x         = 32'(r_oex);
    assign o_eye_y         = 32'(r_oey);
    assign o_eye_z         = 32'(r_oez);
    assign o_focus_x       = 32'(r_ofx);
    assign o_focus_y       = 32'(r_ofy);
    assign o_focus_z       = 32'(r_ofz);
    assign o_range_out     = r_orange;
    assign o_azimuth_out   = r_oaz;
    assign o_elevation_out = r_oel;

    `OCU_ALWAYS(a_range_bounds, (r_range >= 26'd66) && (r_range <= 26'd65536000), "range")
    `OCU_ALWAYS(a_elev_bounds, (r_el >= -16'sd22784) && (r_el <= 16'sd22784), "elevation")
    `OCU_ALWAYS(a_azim_bounds, (r_az >= -17'sd46080) && (r_az <= 17'sd46080), "azimuth")
    `OCU_IMPLY(a_cor_step, r_state == S_COR, r_cstep <= LastStep, "CORDIC step overrun")
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the orbit camera update block.
module tb_top;

    localparam int STEPS = 16;
    localparam int PW = 32;
    localparam longint CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic [1:0] i_action;
    logic signed [15:0] i_move_x;
    logic signed [15:0] i_move_y;
    logic signed [1:0] i_wheel;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [31:0] o_eye_x, o_eye_y, o_eye_z;
    logic signed [31:0] o_focus_x, o_focus_y, o_focus_z;
    logic [25:0] o_range_out;
    logic signed [16:0] o_azimuth_out;
    logic signed [15:0] o_elevation_out;

    typedef struct packed {
        logic [31:0] eye_x, eye_y, eye_z, foc_x, foc_y, foc_z;
        logic [25:0] rng;
        logic [16:0] az;
        logic [15:0] el;
    } t_view;

    t_view view_q[$];
    longint cam_az, cam_el, cam_rng, cam_foc[3];
    int mismatches;
    longint cycles = 0;
    bit hold_off;
    int items_sent;

    orbit_camera_update i_dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_pos(longint v);
        longint lim;
        lim = (longint'(1) << (PW - 1)) - 1;
        if (v > lim) return lim;
        if (v < -lim - 1) return -lim - 1;
        return v;
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit flip;
        z = ang * 256;
        x = 39797;
        y = 0;
        flip = 0;
        if (z > 5898240) begin
            z -= 11796480; flip = 1;
        end else if (z < -5898240) begin
            z += 11796480; flip = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ocu_pkg::atan_q16(i[4:0]));
            end else begin
                x += dx; y -= dy; z += longint'(ocu_pkg::atan_q16(i[4:0]));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic camera_step(input ocu_pkg::t_action act, input logic signed [15:0] mx16,
                               input logic signed [15:0] my16, input logic signed [1:0] wh2);
        longint mx, my, wh, scale, sa, ca, se, ce, rc, t, u, ex, ey, ez;
        t_view v;
        mx = mx16; my = my16; wh = wh2;
        scale = round_shift(cam_rng * 50332, 16);
        case (act)
            ocu_pkg::ACT_ROTATE: begin
                cam_az += mx;
                if (cam_az > 46080) cam_az -= 92160;
                if (cam_az < -46080) cam_az += 92160;
                cam_el += my;
                if (cam_el < -22784) cam_el = -22784;
                if (cam_el > 22784) cam_el = 22784;
            end
            ocu_pkg::ACT_PAN_XY: begin
                sin_cos(cam_az, sa, ca);
                t = mx * ca - my * sa;
                u = mx * sa + my * ca;
                cam_foc[1] = clamp_pos(cam_foc[1] + round_shift(scale * t, 32));
                cam_foc[0] = clamp_pos(cam_foc[0] - round_shift(scale * u, 32));
            end
            ocu_pkg::ACT_PAN_Z:
                cam_foc[2] = clamp_pos(cam_foc[2] - round_shift(scale * my, 16));
            default: begin
                if (wh > 0) begin
                    cam_rng = round_shift(cam_rng * 75366, 16);
                    if (cam_rng > 65536000) cam_rng = 65536000;
                end else if (wh < 0) begin
                    cam_rng = round_shift(cam_rng * 56988, 16);
                    if (cam_rng < 66) cam_rng = 66;
                end
            end
        endcase
        sin_cos(cam_az, sa, ca);
        sin_cos(cam_el, se, ce);
        rc = round_shift(cam_rng * ce, 16);
        ex = clamp_pos(cam_foc[0] + round_shift(rc * ca, 16));
        ey = clamp_pos(cam_foc[1] + round_shift(rc * sa, 16));
        ez = clamp_pos(cam_foc[2] - round_shift(cam_rng * se, 16));
        v.eye_x = ex[31:0]; v.eye_y = ey[31:0]; v.eye_z = ez[31:0];
        v.foc_x = cam_foc[0][31:0]; v.foc_y = cam_foc[1][31:0];
        v.foc_z = cam_foc[2][31:0];
        v.rng = cam_rng[25:0]; v.az = cam_az[16:0]; v.el = cam_el[15:0];
        view_q.push_back(v);
    endtask

    // sender: one transfer per call, random gap before it unless no_gap is set
    task automatic send_event(input ocu_pkg::t_action act, input logic signed [15:0] mx,
                              input logic signed [15:0] my, input logic signed [1:0] wh,
                              input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        if (gap != 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_action <= act;
        i_move_x <= mx;
        i_move_y <= my;
        i_wheel <= wh;
        do @(posedge i_clk); while (o_in_stall);
        camera_step(act, mx, my, wh);
        items_sent++;
    endtask

    // receiver stall pattern
    initial begin
        int wait_n;
        i_out_stall = 1;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_out_stall <= 1;
                @(posedge i_clk);
            end else begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (wait_n != 0) begin
                    i_out_stall <= 1;
                    repeat (wait_n) @(posedge i_clk);
                end
                i_out_stall <= 0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_view got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_eye_x, o_eye_y, o_eye_z, o_focus_x, o_focus_y, o_focus_z,
                   o_range_out, o_azimuth_out, o_elevation_out};
            if (view_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                want = view_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp eye %0d %0d %0d foc %0d %0d %0d r %0d",
                                  " az %0d el %0d / got eye %0d %0d %0d foc %0d %0d %0d",
                                  " r %0d az %0d el %0d"},
                            $signed(want.eye_x), $signed(want.eye_y), $signed(want.eye_z),
                            $signed(want.foc_x), $signed(want.foc_y), $signed(want.foc_z),
                            want.rng, $signed(want.az), $signed(want.el),
                            o_eye_x, o_eye_y, o_eye_z, o_focus_x, o_focus_y, o_focus_z,
                            o_range_out, o_azimuth_out, o_elevation_out);
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_move();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 2048)) - 1024);
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : -16'sh8000;
            default: return 16'($signed($urandom_range(0, 256)) - 128);
        endcase
    endfunction

    task automatic test_directed();
        send_event(ocu_pkg::ACT_ROTATE, 16'sd0, 16'sd0, 2'sd0);
        send_event(ocu_pkg::ACT_ROTATE, 16'sh7fff, 16'sh7fff, -2'sd1);
        send_event(ocu_pkg::ACT_ROTATE, 16'sh7fff, 16'sh7fff, 2'sd1);
        send_event(ocu_pkg::ACT_ROTATE, -16'sh8000, -16'sh8000, -2'sd2);
        send_event(ocu_pkg::ACT_ROTATE, -16'sh8000, -16'sh8000, 2'sd0);
        send_event(ocu_pkg::ACT_PAN_XY, 16'sh7fff, -16'sh8000, 2'sd1);
        send_event(ocu_pkg::ACT_PAN_XY, -16'sh8000, 16'sh7fff, -2'sd2);
        send_event(ocu_pkg::ACT_PAN_Z, 16'sh1234, 16'sh7fff, 2'sd1);
        send_event(ocu_pkg::ACT_PAN_Z, -16'sh8000, -16'sh8000, 2'sd0);
        send_event(ocu_pkg::ACT_SCROLL, 16'sh7fff, 16'sh7fff, 2'sd0);
        send_event(ocu_pkg::ACT_SCROLL, 16'sd5, 16'sd5, -2'sd2);
        // zoom out past the top limit, then pan hard at the largest range
        repeat (60) send_event(ocu_pkg::ACT_SCROLL, 16'sd0, 16'sd0, 2'sd1, 1);
        repeat (6) send_event(ocu_pkg::ACT_PAN_Z, 16'sd0, -16'sh8000, 2'sd0, 1);
        repeat (6) send_event(ocu_pkg::ACT_PAN_XY, -16'sh8000, -16'sh8000, 2'sd0, 1);
        // zoom in past the bottom limit
        repeat (110) send_event(ocu_pkg::ACT_SCROLL, 16'sd0, 16'sd0, -2'sd1, 1);
        repeat (40) send_event(ocu_pkg::ACT_SCROLL, 16'sd0, 16'sd0, 2'sd1, 1);
    endtask

    task automatic test_random();
        repeat (160) send_event(ocu_pkg::t_action'($urandom_range(0, 3)), rand_move(),
                                rand_move(), 2'($urandom));
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            repeat (8) send_event(ocu_pkg::t_action'($urandom_range(0, 3)), rand_move(),
                                  rand_move(), 2'($urandom), 1);
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 0;
            end
        join
    endtask

    initial begin
        mismatches = 0;
        hold_off = 0;
        items_sent = 0;
        cam_az = 0; cam_el = 0; cam_rng = 655360;
        cam_foc[0] = 0; cam_foc[1] = 0; cam_foc[2] = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_action = ocu_pkg::ACT_ROTATE;
        i_move_x = 0;
        i_move_y = 0;
        i_wheel = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        i_in_valid <= 0;
        while (view_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && view_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/ocu_pkg.sv
design/orbit_camera_update.sv
dv/tb_top.sv
